// ===== hw/rtl/cals_pkg.sv =====
package cals_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned ChanW  = 8;
  localparam int unsigned ColorW = 3 * ChanW;
  localparam int unsigned CountW = 8;
  localparam int unsigned LimitW = 9;
  localparam int unsigned CfgIdxW = 2;

  // Longest arm the hardware will ever report.
  localparam logic [CountW-1:0] MaxArm = 8'd255;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ARM_LIMIT   = 2'd0,
    CFG_LONG_START  = 2'd1,
    CFG_NEAR_LIMIT  = 2'd2,
    CFG_FAR_LIMIT   = 2'd3
  } cfg_index_t;

  // Reset values of the configuration registers.
  localparam logic [CountW-1:0] ArmLimitRst  = 8'd34;
  localparam logic [CountW-1:0] LongStartRst = 8'd17;
  localparam logic [LimitW-1:0] NearLimitRst = 9'd20;
  localparam logic [LimitW-1:0] FarLimitRst  = 9'd6;

  typedef struct packed {
    logic [CountW-1:0] arm_limit;
    logic [CountW-1:0] long_arm_start;
    logic [LimitW-1:0] near_color_limit;
    logic [LimitW-1:0] far_color_limit;
  } cals_cfg_t;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } color_t;

  typedef struct packed {
    color_t color;
    logic   is_center;
    logic   is_final;
  } pixel_t;

  typedef struct packed {
    logic              emit;
    logic [CountW-1:0] arm_length;
  } walk_result_t;

endpackage

// ===== hw/rtl/cals_dist.sv =====
module cals_dist
  import cals_pkg::*;
(
  input  color_t           a,
  input  color_t           b,
  output logic [ChanW-1:0] max_diff
);

  logic [ChanW-1:0] d_red;
  logic [ChanW-1:0] d_green;
  logic [ChanW-1:0] d_blue;
  logic [ChanW-1:0] d_rg;

  // Absolute difference per channel.
  assign d_red   = (a.red   > b.red)   ? a.red   - b.red   : b.red   - a.red;
  assign d_green = (a.green > b.green) ? a.green - b.green : b.green - a.green;
  assign d_blue  = (a.blue  > b.blue)  ? a.blue  - b.blue  : b.blue  - a.blue;

  // Largest of the three.
  assign d_rg     = (d_green > d_red) ? d_green : d_red;
  assign max_diff = (d_blue > d_rg) ? d_blue : d_rg;

endmodule

// ===== hw/rtl/cals_walk.sv =====
module cals_walk
  import cals_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  pixel_t       pix,
  input  cals_cfg_t    cfg,
  output walk_result_t res
);

  color_t            anchor_color;
  color_t            previous_color;
  logic [CountW-1:0] arm_count;
  logic              walking;
  logic              halted;

  color_t            previous_color_next;
  logic [CountW-1:0] arm_count_next;
  logic              walking_next;
  logic              halted_next;

  logic [ChanW-1:0]  d_anchor;
  logic [ChanW-1:0]  d_prev;
  logic [CountW-1:0] limit;
  logic [CountW:0]   count_inc;
  logic              far_active;
  logic              ok;

  cals_dist u_dist_anchor (
    .a        (pix.color),
    .b        (anchor_color),
    .max_diff (d_anchor)
  );

  cals_dist u_dist_prev (
    .a        (pix.color),
    .b        (previous_color),
    .max_diff (d_prev)
  );

  // Acceptance test for one neighbor.
  assign limit      = (cfg.arm_limit < MaxArm) ? cfg.arm_limit : MaxArm;
  assign count_inc  = {1'b0, arm_count} + 1'b1;
  assign far_active = count_inc > {1'b0, cfg.long_arm_start};
  assign ok = (arm_count < limit)
              && ({1'b0, d_anchor} < cfg.near_color_limit)
              && ({1'b0, d_prev} < cfg.near_color_limit)
              && !(far_active && ({1'b0, d_anchor} >= cfg.far_color_limit));

  // Walk state update for the item in the input register.
  always_comb begin
    previous_color_next = previous_color;
    arm_count_next      = arm_count;
    walking_next        = walking;
    halted_next         = halted;
    res.emit            = 1'b0;
    if (pix.is_center) begin
      previous_color_next = pix.color;
      arm_count_next      = '0;
      halted_next         = 1'b0;
      walking_next        = 1'b1;
    end else if (walking && !halted) begin
      if (ok) begin
        arm_count_next      = count_inc[CountW-1:0];
        previous_color_next = pix.color;
      end else begin
        halted_next = 1'b1;
      end
    end
    // A neighbor outside any walk is dropped, final flag included.
    if (pix.is_final && (pix.is_center || walking)) begin
      res.emit     = 1'b1;
      walking_next = 1'b0;
      halted_next  = 1'b0;
    end
    res.arm_length = arm_count_next;
  end

  // Walk state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_color   <= '0;
      previous_color <= '0;
      arm_count      <= '0;
      walking        <= 1'b0;
      halted         <= 1'b0;
    end else if (adv) begin
      if (pix.is_center) begin
        anchor_color <= pix.color;
      end
      previous_color <= previous_color_next;
      arm_count      <= arm_count_next;
      walking        <= walking_next;
      halted         <= halted_next;
    end
  end

endmodule

// ===== hw/rtl/cross_arm_length_scan.sv =====
// Channel  | Direction | Signals                     | Contents
// ---------+-----------+-----------------------------+------------------------------------
// s        | in        | s_tvalid s_tready s_tdata   | pixel; tuser is_center, tlast is_final
//          |           | s_tuser s_tlast             |
// m        | out       | m_tvalid m_tready m_tdata   | arm_length
// cfg      | in        | cfg_we cfg_index cfg_data   | arm and color limits
//
// One pixel per cycle unless a final pixel waits on a stalled result: a transfer
// lands in the input register and is judged in the next cycle by the distance
// compares against the walk state. A result reaches m through the input register
// and then the result register. Reset (rst, synchronous) clears the walk and the
// input and result valid flags and loads the configuration reset values. A stalled
// result holds only final pixels, whether or not they end a walk; others keep flowing.
module cross_arm_length_scan
  import cals_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [ColorW-1:0]  s_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic               s_tuser,   // is_center
  input  logic               s_tlast,   // is_final
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [CountW-1:0]  m_tdata,   // arm_length [7:0]
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [LimitW-1:0]  cfg_data
);

  cals_cfg_t    cfg;
  pixel_t       in_pix;
  logic         in_valid;
  logic         adv;
  logic         out_blocked;
  walk_result_t res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm_limit        <= ArmLimitRst;
      cfg.long_arm_start   <= LongStartRst;
      cfg.near_color_limit <= NearLimitRst;
      cfg.far_color_limit  <= FarLimitRst;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_ARM_LIMIT:  cfg.arm_limit        <= cfg_data[CountW-1:0];
        CFG_LONG_START: cfg.long_arm_start   <= cfg_data[CountW-1:0];
        CFG_NEAR_LIMIT: cfg.near_color_limit <= cfg_data;
        CFG_FAR_LIMIT:  cfg.far_color_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The held pixel moves on unless it is flagged final and the output register is full.
  assign out_blocked = m_tvalid && !m_tready;
  assign adv         = in_valid && !(out_blocked && in_pix.is_final);
  assign s_tready    = !in_valid || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pix.color     <= color_t'({s_tdata[23:16], s_tdata[15:8], s_tdata[7:0]});
      in_pix.is_center <= s_tuser;
      in_pix.is_final  <= s_tlast;
    end
  end

  cals_walk u_walk (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .pix (in_pix),
    .cfg (cfg),
    .res (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && res.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.emit) begin
      m_tdata <= res.arm_length;
    end
  end

endmodule

// ===== hw/rtl/cals_check.sv =====
module cals_check
  import cals_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               s_tuser,
  input logic               s_tlast,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [CountW-1:0]  m_tdata
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or vanished");

  // An anchor at the image edge reports an empty arm once the result register can take it.
  a_edge_anchor: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser && s_tlast) ##1 (!m_tvalid || m_tready)
    |=> m_tvalid && (m_tdata == '0))
    else $error("edge anchor did not report zero length");

endmodule

bind cross_arm_length_scan cals_check u_cals_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
